### src/lph_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and constants of the linear probing hash table: table size,
// field widths, operation and status codes, and the slot store requests.
// ----------------------------------------------------------------------------
package lph_pkg;

    // table geometry (slot count is a power of two: home slot = low key bits)
    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int KEY_W       = 32;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_ZERO_KEY = 2'd2;

    // write request to the slot store
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [KEY_W-1:0]  data;
    } t_wr_req;

    // read request to the slot store
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } t_rd_req;

    // wrap-around successor of a slot index
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W-1:0] res;
        if (idx == SLOT_W'(TABLE_SLOTS - 1)) begin
            res = '0;
        end else begin
            res = idx + SLOT_W'(1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### src/lph_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_store
// Slot key memory: one write port, one read port with registered read data.
// Per-slot valid flags are cleared by reset, so an unwritten slot reads as
// the empty key.
// ----------------------------------------------------------------------------
module lph_store
    import lph_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_wr_req          i_wr,
    input  wire t_rd_req          i_rd,
    output logic [KEY_W-1:0]      o_rd_data
);

    logic [KEY_W-1:0]       r_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_slot_valid;
    logic [KEY_W-1:0]       r_rd_data;
    logic                   r_rd_valid;

    // key array write
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    // valid flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_rd_valid   <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_slot_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_valid <= r_slot_valid[i_rd.addr];
            end
        end
    end

    // never-written slot reads as empty
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule
`default_nettype wire

### src/linear_probe_hash_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing hash table of 32-bit keys with linear probing, optional
// replacement of misplaced occupants, and search with probe counting.
// ----------------------------------------------------------------------------
// One item is processed at a time. The keys live in a 16-slot memory with a
// single read port, and probing walks it one slot per cycle: an item reads p
// slots, 1 to 16, between its input transfer and its result being loaded into
// the output register, while a zero key or an insert into a full table goes
// straight to its result register without reading any slot of the table. An
// insert with displacement writes the new key into its home slot and carries
// on probing from the next slot for the displaced key, in the same walk.
// The output register lets the next input be taken while a result waits.
// Reset clears the table at once through per-slot valid flags (no clearing
// pass) and sets replace_mode to 1.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core
    import lph_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_replace_mode,
    // input items
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_op,
    input  wire logic [KEY_W-1:0]  i_key,
    // result items
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_found,
    output logic [SLOT_W-1:0]      o_slot,
    output logic [CNT_W-1:0]       o_probe_count,
    output logic [1:0]             o_status
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PROBE = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic                r_mode;
    logic                r_op, n_op;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [SLOT_W-1:0]   r_ptr, n_ptr;
    logic [SLOT_W-1:0]   r_home, n_home;
    logic [CNT_W-1:0]    r_dist, n_dist;
    logic                r_disp, n_disp;
    logic [KEY_W-1:0]    r_moved, n_moved;
    logic [CNT_W-1:0]    r_filled, n_filled;
    // pending result
    logic                r_res_found, n_res_found;
    logic [SLOT_W-1:0]   r_res_slot, n_res_slot;
    logic [CNT_W-1:0]    r_res_probe, n_res_probe;
    logic [1:0]          r_res_status, n_res_status;
    // output register
    logic                r_out_valid;
    logic                r_out_found;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [CNT_W-1:0]    r_out_probe;
    logic [1:0]          r_out_status;

    t_wr_req             w_wr;
    t_rd_req             w_rd;
    logic [KEY_W-1:0]    w_rd_data;
    logic                w_in_xfer;
    logic                w_out_load;
    logic [SLOT_W-1:0]   w_next;
    logic [SLOT_W-1:0]   w_in_home;

    // slot memory
    lph_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd      (w_rd),
        .o_rd_data (w_rd_data)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_valid && o_ready;
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || i_ready);
    assign w_next      = next_slot(r_ptr);
    assign w_in_home   = i_key[SLOT_W-1:0];

    // probe sequencer
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_ptr        = r_ptr;
        n_home       = r_home;
        n_dist       = r_dist;
        n_disp       = r_disp;
        n_moved      = r_moved;
        n_filled     = r_filled;
        n_res_found  = r_res_found;
        n_res_slot   = r_res_slot;
        n_res_probe  = r_res_probe;
        n_res_status = r_res_status;
        w_wr         = '0;
        w_rd.en      = 1'b0;
        w_rd.addr    = w_next;

        case (r_state)
            S_IDLE: begin
                w_rd.addr = w_in_home;
                if (w_in_xfer) begin
                    n_op         = i_op;
                    n_key        = i_key;
                    n_ptr        = w_in_home;
                    n_home       = w_in_home;
                    n_dist       = '0;
                    n_disp       = 1'b0;
                    n_res_found  = 1'b0;
                    n_res_slot   = '0;
                    n_res_probe  = '0;
                    n_res_status = ST_OK;
                    if (i_key == '0) begin
                        n_res_status = ST_ZERO_KEY;
                        n_state      = S_DONE;
                    end else if (i_op == OP_INSERT && r_filled >= CNT_W'(TABLE_SLOTS)) begin
                        n_res_status = ST_FULL;
                        n_state      = S_DONE;
                    end else begin
                        w_rd.en = 1'b1;
                        n_state = S_PROBE;
                    end
                end
            end

            S_PROBE: begin
                if (r_op == OP_SEARCH) begin
                    // search: stop on hit, empty slot or a full pass
                    if (w_rd_data == r_key) begin
                        n_res_found = 1'b1;
                        n_res_slot  = r_ptr;
                        n_res_probe = r_dist;
                        n_state     = S_DONE;
                    end else if (w_rd_data == '0) begin
                        n_res_probe = r_dist;
                        n_state     = S_DONE;
                    end else if (r_dist == CNT_W'(TABLE_SLOTS - 1)) begin
                        n_res_probe = r_dist + CNT_W'(1);
                        n_state     = S_DONE;
                    end else begin
                        w_rd.en = 1'b1;
                        n_ptr   = w_next;
                        n_dist  = r_dist + CNT_W'(1);
                    end
                end else if (!r_disp && r_dist == '0 && r_mode && w_rd_data != '0
                             && w_rd_data[SLOT_W-1:0] != r_ptr) begin
                    // home occupant belongs elsewhere: take its slot, rehome it
                    w_wr.en   = 1'b1;
                    w_wr.addr = r_ptr;
                    w_wr.data = r_key;
                    n_moved   = w_rd_data;
                    n_disp    = 1'b1;
                    w_rd.en   = 1'b1;
                    n_ptr     = w_next;
                    n_dist    = r_dist + CNT_W'(1);
                end else if (w_rd_data == '0) begin
                    // empty slot: store the probing key
                    w_wr.en     = 1'b1;
                    w_wr.addr   = r_ptr;
                    w_wr.data   = r_disp ? r_moved : r_key;
                    n_filled    = r_filled + CNT_W'(1);
                    n_res_slot  = r_disp ? r_home : r_ptr;
                    n_res_probe = r_dist;
                    n_state     = S_DONE;
                end else begin
                    w_rd.en = 1'b1;
                    n_ptr   = w_next;
                    n_dist  = r_dist + CNT_W'(1);
                end
            end

            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_filled <= '0;
            r_mode   <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_filled <= n_filled;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_replace_mode;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_ptr        <= n_ptr;
        r_home       <= n_home;
        r_dist       <= n_dist;
        r_disp       <= n_disp;
        r_moved      <= n_moved;
        r_res_found  <= n_res_found;
        r_res_slot   <= n_res_slot;
        r_res_probe  <= n_res_probe;
        r_res_status <= n_res_status;
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_found  <= r_res_found;
            r_out_slot   <= r_res_slot;
            r_out_probe  <= r_res_probe;
            r_out_status <= r_res_status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_found       = r_out_found;
    assign o_slot        = r_out_slot;
    assign o_probe_count = r_out_probe;
    assign o_status      = r_out_status;

`ifndef SYNTHESIS
    // occupancy never exceeds the table
    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CNT_W'(TABLE_SLOTS))
        else $error("fill count above table size");

    // a store only happens while the table has room
    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr.en && r_state == S_PROBE && w_rd_data == '0) |-> r_filled < CNT_W'(TABLE_SLOTS))
        else $error("key stored into full table");

    // a displacement write is always followed by further probing
    a_disp_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && !r_disp && n_disp) |=> (r_state == S_PROBE && r_disp))
        else $error("displaced key left without a slot");

    // a hit is only reported as a successful search
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_res_found) |-> (r_res_status == ST_OK && r_op == OP_SEARCH))
        else $error("found flag on non-search result");

    // probing distance stays inside one pass
    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PROBE |-> r_dist < CNT_W'(TABLE_SLOTS))
        else $error("probe walked past one full pass");
`endif

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for linear_probe_hash_table_core. A scoreboard keeps a
// shadow copy of the slot table and works out each expected answer when the
// request transfer happens. Directed requests walk through zero keys, wrap
// around, displacement, duplicates, search misses and a full table under both
// probing modes. A random mix then follows with random gaps on both sides,
// a stretch with no gaps, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import lph_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASE_COUNT  = 10;
    localparam int STALL_CYCLES = 300;

    // one expected answer, with the request that caused it
    typedef struct {
        logic              op;
        logic [KEY_W-1:0]  key;
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  probes;
        logic [1:0]        status;
    } t_lookup_answer;

    // shadow hash table and queue of answers still owed by the block
    class probe_table_scoreboard;
        logic [KEY_W-1:0] slot_keys [TABLE_SLOTS];
        int               filled;
        logic             replace_mode;
        t_lookup_answer   owed_answers[$];
        int               mismatches;
        int               answers_seen;

        function new();
            foreach (slot_keys[i]) slot_keys[i] = '0;
            filled       = 0;
            replace_mode = 1'b1;
            mismatches   = 0;
            answers_seen = 0;
        endfunction

        function int pending();
            return owed_answers.size();
        endfunction

        function void set_mode(logic mode);
            replace_mode = mode;
        endfunction

        function logic [SLOT_W-1:0] home_of(logic [KEY_W-1:0] key);
            return SLOT_W'(key % TABLE_SLOTS);
        endfunction

        function logic [KEY_W-1:0] pick_stored();
            return slot_keys[$urandom_range(0, TABLE_SLOTS - 1)];
        endfunction

        // work out the answer to an accepted request and update the table
        function void predict_lookup(logic op, logic [KEY_W-1:0] key);
            t_lookup_answer    ans;
            logic [SLOT_W-1:0] home;
            logic [SLOT_W-1:0] idx;
            logic [KEY_W-1:0]  moved;
            int                steps;
            ans        = '{default: '0};
            ans.op     = op;
            ans.key    = key;
            ans.status = ST_OK;
            home       = home_of(key);
            // slot count is a power of two, so idx + 1 wraps by itself
            if (key == '0) begin
                ans.status = ST_ZERO_KEY;
            end else if (op == OP_SEARCH) begin
                idx   = home;
                steps = 0;
                while (steps < TABLE_SLOTS && slot_keys[idx] != key
                       && slot_keys[idx] != '0) begin
                    idx = idx + 1'b1;
                    steps++;
                end
                if (steps < TABLE_SLOTS && slot_keys[idx] == key) begin
                    ans.found = 1'b1;
                    ans.slot  = idx;
                end
                ans.probes = CNT_W'(steps);
            end else if (filled >= TABLE_SLOTS) begin
                ans.status = ST_FULL;
            end else if (replace_mode && slot_keys[home] != '0
                         && home_of(slot_keys[home]) != home) begin
                // misplaced occupant gives way and moves to the next empty slot
                moved           = slot_keys[home];
                slot_keys[home] = key;
                idx             = home + 1'b1;
                steps           = 0;
                while (slot_keys[idx] != '0) begin
                    idx = idx + 1'b1;
                    steps++;
                end
                slot_keys[idx] = moved;
                filled++;
                ans.slot   = home;
                ans.probes = CNT_W'(steps + 1);
            end else begin
                idx   = home;
                steps = 0;
                while (slot_keys[idx] != '0) begin
                    idx = idx + 1'b1;
                    steps++;
                end
                slot_keys[idx] = key;
                filled++;
                ans.slot   = idx;
                ans.probes = CNT_W'(steps);
            end
            owed_answers.push_back(ans);
        endfunction

        task report(string what);
            if (mismatches < 40) $display("ERROR answer %0d: %s", answers_seen, what);
            mismatches++;
        endtask

        // compare one output transfer with the oldest owed answer
        task check_answer(logic found, logic [SLOT_W-1:0] slot,
                          logic [CNT_W-1:0] probes, logic [1:0] status);
            t_lookup_answer want;
            if (owed_answers.size() == 0) begin
                report("output transfer with no request outstanding");
            end else begin
                want = owed_answers.pop_front();
                if (found !== want.found)
                    report($sformatf("op %0b key %h found got %b want %b",
                                     want.op, want.key, found, want.found));
                if (slot !== want.slot)
                    report($sformatf("op %0b key %h slot got %0d want %0d",
                                     want.op, want.key, slot, want.slot));
                if (probes !== want.probes)
                    report($sformatf("op %0b key %h probe_count got %0d want %0d",
                                     want.op, want.key, probes, want.probes));
                if (status !== want.status)
                    report($sformatf("op %0b key %h status got %0d want %0d",
                                     want.op, want.key, status, want.status));
            end
            answers_seen++;
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_replace_mode;
    logic              i_valid;
    logic              o_ready;
    logic              i_op;
    logic [KEY_W-1:0]  i_key;
    logic              o_valid;
    logic              i_ready;
    logic              o_found;
    logic [SLOT_W-1:0] o_slot;
    logic [CNT_W-1:0]  o_probe_count;
    logic [1:0]        o_status;

    probe_table_scoreboard table_sb;
    logic                  steady;
    logic                  stall_armed;
    int                    stall_left;
    int                    cycle_count;

    linear_probe_hash_table_core u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_replace_mode (i_cfg_replace_mode),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_op               (i_op),
        .i_key              (i_key),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_found            (o_found),
        .o_slot             (o_slot),
        .o_probe_count      (o_probe_count),
        .o_status           (o_status)
    );

    // clock
    always #HALF_PERIOD i_clk = ~i_clk;

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // output side: random back-pressure, or a long hold-off when armed
    initial begin
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_armed) begin
                stall_armed = 1'b0;
                stall_left  = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= steady || ($urandom_range(0, 99) >= 23);
            end
        end
    end

    // output transfer check
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            table_sb.check_answer(o_found, o_slot, o_probe_count, o_status);
    end

    // one request transfer, with an optional random gap in front
    task automatic send_item(input logic op, input logic [KEY_W-1:0] key);
        while (!steady && $urandom_range(0, 99) < 23) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        do @(posedge i_clk); while (!o_ready);
        table_sb.predict_lookup(op, key);
        @(negedge i_clk);
    endtask

    // mode change once the block has delivered everything
    task automatic write_replace_mode(input logic mode);
        i_valid <= 1'b0;
        while (table_sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_replace_mode <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        table_sb.set_mode(mode);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random key, mostly crowded onto a few home slots to build clusters
    function automatic logic [KEY_W-1:0] clustered_key();
        logic [KEY_W-1:0] k;
        k = $urandom();
        if ($urandom_range(0, 3) != 0)
            k[SLOT_W-1:0] = SLOT_W'(4 * $urandom_range(0, 3) + 3);
        return k;
    endfunction

    task automatic send_random_item();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            send_item(OP_SEARCH, table_sb.pick_stored());
        else if (roll < 62)
            send_item(OP_SEARCH, $urandom());
        else if (roll < 70)
            send_item(OP_SEARCH, clustered_key());
        else if (roll < 74)
            send_item($urandom_range(0, 1) ? OP_SEARCH : OP_INSERT, '0);
        else
            send_item(OP_INSERT, $urandom());
    endtask

    // stimulus
    initial begin
        table_sb           = new();
        steady             = 1'b0;
        stall_armed        = 1'b0;
        i_rst_n            = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_replace_mode = 1'b0;
        i_valid            = 1'b0;
        i_op               = OP_INSERT;
        i_key              = '0;
        i_ready            = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero keys, empty-table miss, wrap-around, displacement, duplicate
        write_replace_mode(1'b1);
        send_item(OP_INSERT, '0);
        send_item(OP_SEARCH, '0);
        send_item(OP_SEARCH, 32'h0000_0005);
        send_item(OP_INSERT, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'h0000_001F);
        send_item(OP_INSERT, 32'h0000_0010);
        send_item(OP_SEARCH, 32'h0000_001F);
        send_item(OP_INSERT, 32'h0000_0010);
        send_item(OP_SEARCH, 32'h0000_0020);

        // plain probing past a misplaced occupant
        write_replace_mode(1'b0);
        send_item(OP_INSERT, 32'h0000_0021);
        send_item(OP_INSERT, 32'h8000_0001);

        // displacement further down a cluster
        write_replace_mode(1'b1);
        send_item(OP_INSERT, 32'h0000_0002);
        send_item(OP_SEARCH, 32'h0000_0010);
        send_item(OP_SEARCH, 32'hAAAA_5555);

        // fill the rest of the table under both modes
        write_replace_mode(1'b0);
        while (table_sb.filled < 11)
            send_item($urandom_range(0, 3) == 0 ? OP_SEARCH : OP_INSERT, clustered_key());
        write_replace_mode(1'b1);
        while (table_sb.filled < TABLE_SLOTS)
            send_item($urandom_range(0, 3) == 0 ? OP_SEARCH : OP_INSERT, clustered_key());

        // full table: rejected insert, full-pass miss, zero key precedence
        send_item(OP_INSERT, 32'h1234_5677);
        send_item(OP_SEARCH, 32'h5A5A_A5A6);
        send_item(OP_INSERT, '0);
        write_replace_mode(1'b0);
        send_item(OP_INSERT, 32'h7654_3210);

        // random mix, modes alternating, one phase without gaps and a hold-off
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            write_replace_mode(phase[0]);
            steady = (phase == 4);
            if (phase == 4) stall_armed = 1'b1;
            repeat (PHASE_ITEMS) send_random_item();
        end
        steady = 1'b0;

        // drain and finish
        i_valid <= 1'b0;
        while (table_sb.pending() != 0) @(negedge i_clk);
        repeat (24) @(negedge i_clk);
        if (table_sb.mismatches == 0 && table_sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
